[rtl/wwp_pkg.sv]
// Package for the greedy word-wrap glyph placer.
// Holds the shared codes, register indexes, sequencer states and bundle types.
// No dependencies; every other file refers to it by scoped names.
package wwp_pkg;

  // Character kinds as they arrive on the input channel.
  localparam logic [1:0] KIND_SPACE    = 2'd0;
  localparam logic [1:0] KIND_GLYPH    = 2'd1;
  localparam logic [1:0] KIND_NONDRAWN = 2'd2;
  localparam logic [1:0] KIND_OTHER    = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER      = 3'd5;

  localparam int unsigned CFG_DATA_W = 16;

  // Most placements produced by one request.
  localparam logic [5:0] RESULT_CAP = 6'd32;

  localparam logic [7:0]  GLYPH_SIZE_RST = 8'd8;
  localparam logic [15:0] SAT16_MAX     = 16'hFFFF;
  localparam logic [19:0] SAT20_MAX     = 20'hFFFFF;

  // One buffered character of the current word.
  typedef struct packed {
    logic [15:0] tile;
    logic [1:0]  kind;
  } glyph_entry_t;

  // Operands of the shared saturating adder.
  typedef struct packed {
    logic [19:0] a;
    logic [19:0] b;
    logic        sat16;
  } alu_req_t;

  typedef struct packed {
    logic [20:0] sum;
    logic [19:0] sat;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_WIDTH,
    ST_CHECK,
    ST_WRAP,
    ST_LINE,
    ST_EMIT,
    ST_STEP,
    ST_SPACE,
    ST_DONE
  } seq_state_t;

endpackage

[rtl/wwp_if.sv]
// Channel interfaces of the greedy word-wrap glyph placer.
// Character input, placement output and configuration write channels.
// Depends on wwp_pkg.
interface wwp_char_if;
  logic        valid;
  logic        ready;
  logic [1:0]  char_kind;
  logic [15:0] texture_id;
  logic        last_char;

  modport source (output valid, char_kind, texture_id, last_char, input ready);
  modport sink (input valid, char_kind, texture_id, last_char, output ready);
endinterface

interface wwp_place_if;
  logic        valid;
  logic        ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] glyph_tile;
  logic signed [15:0] depth_layer;
  logic        run_end;
  logic        word_truncated;

  modport source (output valid, pos_x, pos_y, glyph_tile, depth_layer, run_end,
                  word_truncated, input ready);
  modport sink (input valid, pos_x, pos_y, glyph_tile, depth_layer, run_end,
                word_truncated, output ready);
endinterface

interface wwp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wwp_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [wwp_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

[rtl/wwp_alu.sv]
// Shared saturating adder of the word-wrap placer.
// Every width, line and column sum of the sequencer passes through here.
// Depends on wwp_pkg.
module wwp_alu (
  input  wwp_pkg::alu_req_t req,
  output wwp_pkg::alu_rsp_t rsp
);

  logic [20:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    rsp.sum = sum;
    if (req.sat16) begin
      rsp.sat = (sum > 21'(wwp_pkg::SAT16_MAX)) ? 20'(wwp_pkg::SAT16_MAX) : sum[19:0];
    end else begin
      rsp.sat = (sum > 21'(wwp_pkg::SAT20_MAX)) ? wwp_pkg::SAT20_MAX : sum[19:0];
    end
  end

endmodule

[rtl/wwp_word_buf.sv]
// Word buffer of the word-wrap placer: one write port, one registered read port.
// Holds the characters of the word being collected.
// Depends on wwp_pkg.
module wwp_word_buf #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wwp_pkg::glyph_entry_t      wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output wwp_pkg::glyph_entry_t      rd_data
);

  wwp_pkg::glyph_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/greedy_word_wrap_placer.sv]
// Greedy word-wrap glyph placer, top level with the flush sequencer.
// A character that does not end a word is accepted while idle. A word end runs MUL,
// WIDTH, CHECK, WRAP on a wrap, LINE, then EMIT and STEP per buffered character and
// SPACE if a space ends it; the shared adder does every sum in turn; stalls hold EMIT.
// Synchronous reset clears the word and line state and loads the register defaults.
module greedy_word_wrap_placer #(
  parameter int unsigned WORD_MAX = 32
) (
  input  logic              clk,
  input  logic              rst,
  wwp_char_if.sink          chars,
  wwp_place_if.source       places,
  wwp_cfg_if.sink           cfg
);

  localparam int unsigned AW = $clog2(WORD_MAX);
  localparam int unsigned LW = $clog2(WORD_MAX + 1);
  localparam int unsigned PW = LW + 9;

  // Configuration registers.
  logic [15:0]        start_x;
  logic [15:0]        start_y;
  logic [15:0]        box_width;
  logic [7:0]         glyph_size;
  logic [7:0]         glyph_gap;
  logic signed [15:0] layer;

  // Word and line state.
  wwp_pkg::seq_state_t state, state_next;
  logic [LW-1:0] len;
  logic [LW-1:0] drawn;
  logic          ovf;
  logic          ended_space;
  logic          is_last;
  logic [19:0]   luw;
  logic [15:0]   col;
  logic [15:0]   row_y;
  logic [PW-1:0] prod;
  logic [16:0]   width;
  logic [LW-1:0] idx;
  logic [5:0]    cnt;

  // Output register.
  logic               out_valid;
  logic [15:0]        out_pos_x;
  logic [15:0]        out_pos_y;
  logic [15:0]        out_tile;
  logic signed [15:0] out_layer;
  logic               out_run_end;
  logic               out_trunc;

  logic [8:0]    step;
  logic [1:0]    kind_n;
  logic          accept;
  logic          flush_req;
  logic          buf_wr;
  logic          buf_rd;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] idx_inc;
  logic [LW-1:0] len_m1;
  logic [6:0]    cap;
  logic          emit_glyph;
  logic          out_busy;
  logic          load_out;
  logic          wrap_hit;
  logic [16:0]   empty_width;

  wwp_pkg::glyph_entry_t wr_entry;
  wwp_pkg::glyph_entry_t rd_entry;
  wwp_pkg::alu_req_t     alu_req;
  wwp_pkg::alu_rsp_t     alu_rsp;

  wwp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  wwp_word_buf #(
    .DEPTH (WORD_MAX)
  ) u_word_buf (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (len[AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (buf_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign step      = {1'b0, glyph_size} + {1'b0, glyph_gap};
  assign kind_n    = (chars.char_kind == wwp_pkg::KIND_OTHER) ? wwp_pkg::KIND_NONDRAWN
                                                             : chars.char_kind;
  assign accept    = chars.valid && chars.ready;
  assign flush_req = (kind_n == wwp_pkg::KIND_SPACE) || chars.last_char;
  assign buf_wr    = accept && (kind_n != wwp_pkg::KIND_SPACE) && (len < LW'(WORD_MAX));
  assign wr_entry  = '{tile: chars.texture_id, kind: kind_n};
  assign idx_inc   = idx + LW'(1);
  assign len_m1    = len - LW'(1);
  assign cap       = (7'(drawn) > 7'(wwp_pkg::RESULT_CAP)) ? 7'(wwp_pkg::RESULT_CAP)
                                                           : 7'(drawn);
  assign emit_glyph = (rd_entry.kind == wwp_pkg::KIND_GLYPH) && (cnt < wwp_pkg::RESULT_CAP);
  assign out_busy   = out_valid && !places.ready;
  assign wrap_hit   = (col != 16'd0) && (alu_rsp.sum > 21'(box_width));
  assign empty_width = (glyph_size > glyph_gap) ? 17'(glyph_size - glyph_gap) : 17'd0;

  assign cfg.ready = 1'b1;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      wwp_pkg::ST_IDLE: begin
        if (accept && flush_req) state_next = wwp_pkg::ST_MUL;
      end
      wwp_pkg::ST_MUL:   state_next = wwp_pkg::ST_WIDTH;
      wwp_pkg::ST_WIDTH: state_next = wwp_pkg::ST_CHECK;
      wwp_pkg::ST_CHECK: begin
        state_next = wrap_hit ? wwp_pkg::ST_WRAP : wwp_pkg::ST_LINE;
      end
      wwp_pkg::ST_WRAP:  state_next = wwp_pkg::ST_LINE;
      wwp_pkg::ST_LINE: begin
        if (len != '0) begin
          state_next = wwp_pkg::ST_EMIT;
        end else begin
          state_next = ended_space ? wwp_pkg::ST_SPACE : wwp_pkg::ST_DONE;
        end
      end
      wwp_pkg::ST_EMIT: begin
        if (!(emit_glyph && out_busy)) state_next = wwp_pkg::ST_STEP;
      end
      wwp_pkg::ST_STEP: begin
        if (idx_inc != len) begin
          state_next = wwp_pkg::ST_EMIT;
        end else begin
          state_next = ended_space ? wwp_pkg::ST_SPACE : wwp_pkg::ST_DONE;
        end
      end
      wwp_pkg::ST_SPACE: state_next = wwp_pkg::ST_DONE;
      wwp_pkg::ST_DONE:  state_next = wwp_pkg::ST_IDLE;
      default:           state_next = wwp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: adder operands, buffer reads and handshakes.
  always_comb begin
    alu_req     = '{a: 20'd0, b: 20'd0, sat16: 1'b0};
    buf_rd      = 1'b0;
    rd_addr     = '0;
    load_out    = 1'b0;
    chars.ready = 1'b0;
    case (state)
      wwp_pkg::ST_IDLE: chars.ready = 1'b1;
      wwp_pkg::ST_WIDTH: begin
        alu_req = '{a: 20'(prod), b: 20'({glyph_size, 1'b0}), sat16: 1'b0};
      end
      wwp_pkg::ST_CHECK: alu_req = '{a: luw, b: 20'(width), sat16: 1'b0};
      wwp_pkg::ST_WRAP:  alu_req = '{a: 20'(row_y), b: 20'(step), sat16: 1'b1};
      wwp_pkg::ST_LINE: begin
        alu_req = '{a: luw, b: 20'(width), sat16: 1'b0};
        buf_rd  = 1'b1;
      end
      wwp_pkg::ST_EMIT: begin
        alu_req  = '{a: 20'(start_x), b: 20'(col), sat16: 1'b1};
        load_out = emit_glyph && !out_busy;
      end
      wwp_pkg::ST_STEP: begin
        alu_req = '{a: 20'(col), b: 20'(step), sat16: 1'b1};
        buf_rd  = 1'b1;
        rd_addr = idx_inc[AW-1:0];
      end
      wwp_pkg::ST_SPACE: alu_req = '{a: 20'(col), b: 20'(step), sat16: 1'b1};
      default: begin
      end
    endcase
  end

  // Configuration registers; a start_y write also moves the current row.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      box_width  <= '0;
      glyph_size <= wwp_pkg::GLYPH_SIZE_RST;
      glyph_gap  <= '0;
      layer      <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        wwp_pkg::CFG_START_X:    start_x    <= cfg.wdata;
        wwp_pkg::CFG_START_Y:    start_y    <= cfg.wdata;
        wwp_pkg::CFG_BOX_WIDTH:  box_width  <= cfg.wdata;
        wwp_pkg::CFG_GLYPH_SIZE: glyph_size <= cfg.wdata[7:0];
        wwp_pkg::CFG_GLYPH_GAP:  glyph_gap  <= cfg.wdata[7:0];
        wwp_pkg::CFG_LAYER:      layer      <= $signed(cfg.wdata);
        default: begin
        end
      endcase
    end
  end

  // Word, line and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= wwp_pkg::ST_IDLE;
      len         <= '0;
      drawn       <= '0;
      ovf         <= 1'b0;
      ended_space <= 1'b0;
      is_last     <= 1'b0;
      luw         <= '0;
      col         <= '0;
      row_y       <= '0;
      idx         <= '0;
      cnt         <= '0;
    end else begin
      state <= state_next;
      case (state)
        wwp_pkg::ST_IDLE: begin
          if (accept) begin
            if (buf_wr) begin
              len <= len + LW'(1);
              if (kind_n == wwp_pkg::KIND_GLYPH) drawn <= drawn + LW'(1);
            end else if (kind_n != wwp_pkg::KIND_SPACE) begin
              ovf <= 1'b1;
            end
            ended_space <= (kind_n == wwp_pkg::KIND_SPACE);
            is_last     <= chars.last_char;
          end
        end
        wwp_pkg::ST_WRAP: begin
          row_y <= alu_rsp.sat[15:0];
          col   <= '0;
          luw   <= '0;
        end
        wwp_pkg::ST_LINE: begin
          luw <= alu_rsp.sat;
          idx <= '0;
        end
        wwp_pkg::ST_EMIT: begin
          if (load_out) cnt <= cnt + 6'd1;
        end
        wwp_pkg::ST_STEP: begin
          col <= alu_rsp.sat[15:0];
          idx <= idx_inc;
        end
        wwp_pkg::ST_SPACE: col <= alu_rsp.sat[15:0];
        wwp_pkg::ST_DONE: begin
          len   <= '0;
          drawn <= '0;
          ovf   <= 1'b0;
          cnt   <= '0;
          if (is_last) begin
            luw   <= '0;
            col   <= '0;
            row_y <= start_y;
          end
        end
        default: begin
        end
      endcase
      if (cfg.valid && cfg.ready && cfg.reg_index == wwp_pkg::CFG_START_Y) begin
        row_y <= cfg.wdata;
      end
    end
  end

  // Word width: 2*glyph + (n-1)*(glyph+gap), or glyph-gap floored at zero when empty.
  always_ff @(posedge clk) begin
    if (state == wwp_pkg::ST_MUL) begin
      prod <= PW'(len_m1) * PW'(step);
    end
    if (state == wwp_pkg::ST_WIDTH) begin
      width <= (len == '0) ? empty_width : alu_rsp.sum[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (places.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pos_x   <= alu_rsp.sat[15:0];
      out_pos_y   <= row_y;
      out_tile    <= rd_entry.tile;
      out_layer   <= layer;
      out_run_end <= (7'(cnt) + 7'd1) == cap;
      out_trunc   <= ovf;
    end
  end

  assign places.valid          = out_valid;
  assign places.pos_x          = out_pos_x;
  assign places.pos_y          = out_pos_y;
  assign places.glyph_tile     = out_tile;
  assign places.depth_layer    = out_layer;
  assign places.run_end        = out_run_end;
  assign places.word_truncated = out_trunc;

  a_len_bound : assert property (@(posedge clk) disable iff (rst)
    len <= LW'(WORD_MAX))
    else $error("word length beyond buffer depth");

  a_cnt_cap : assert property (@(posedge clk) disable iff (rst)
    cnt <= wwp_pkg::RESULT_CAP)
    else $error("more placements than the per-request cap");

  a_emit_in_word : assert property (@(posedge clk) disable iff (rst)
    state == wwp_pkg::ST_EMIT |-> idx < len)
    else $error("emit index outside the buffered word");

  a_flush_clears : assert property (@(posedge clk) disable iff (rst)
    state == wwp_pkg::ST_DONE |=> len == '0 && !ovf && cnt == 6'd0)
    else $error("word state not cleared after flush");

  a_end_of_text : assert property (@(posedge clk) disable iff (rst)
    state == wwp_pkg::ST_DONE && is_last |=> col == 16'd0 && luw == 20'd0)
    else $error("line not restarted after end of text");

endmodule
